// File: hdl/cte_pkg.sv
package cte_pkg;

  localparam logic [1:0] MODE_GAP   = 2'd0;
  localparam logic [1:0] MODE_WORD  = 2'd1;
  localparam logic [1:0] MODE_QUOTE = 2'd2;

  localparam logic [1:0] REG_MIN_LEN   = 2'd0;
  localparam logic [1:0] REG_MAX_EXCL  = 2'd1;
  localparam logic [1:0] REG_MAX_TERMS = 2'd2;

  localparam logic [7:0] MIN_LEN_RST   = 8'd2;
  localparam logic [7:0] MAX_EXCL_RST  = 8'd60;
  localparam logic [7:0] MAX_TERMS_RST = 8'd50;

  localparam logic [7:0] CH_BACKTICK = 8'h60;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_SQUOTE   = 8'h27;

  typedef struct packed {
    logic [7:0] total;
    logic [7:0] idx;
    logic [7:0] chr;
    logic       last;
    logic       done;
  } res_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return (c == CH_BACKTICK) || (c == CH_DQUOTE) || (c == CH_SQUOTE);
  endfunction

  // whitespace (space, tab to carriage return) or printable non-alphanumeric, underscore included
  function automatic logic is_sep(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D)) ||
           ((c >= 8'h21) && (c <= 8'h7E) && !is_upper(c) && !is_lower(c) && !is_digit(c));
  endfunction

endpackage

// File: hdl/camelcase_term_extractor.sv
// Channel   Dir  Request moves
// in_*      in   tuser: kind; tdata: text_byte
// out_*     out  tuser: done_res; tlast: last_of_term; tdata: term_char, term_index, term_total
// cfg_*     in   register index and write data, written on cfg_we
//
// A text byte that closes no term is accepted without stalling. A term is read out of the
// term buffer one character a cycle while the output buffer has room, and input stalls until it ends.
// End of text holds the input for the summary, after the readout of any term that it flushes.
// Results queue in a two-entry output buffer, so a stalled consumer holds the readout but not
// the preceding accept.
// Reset is synchronous; the term buffer is not cleared and needs no clearing pass.
module camelcase_term_extractor #(
  parameter int BUF_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] term_char, [15:8] term_index, [23:16] term_total
  output logic        out_tlast,
  output logic        out_tuser,  // [0] done_res
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  localparam int AW = $clog2(BUF_BYTES);
  localparam int CW = (AW > 7) ? AW : 7;
  localparam logic [AW-1:0] LEN_CAP = AW'(BUF_BYTES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EMIT = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;

  logic [7:0] mem [BUF_BYTES];

  logic [5:0] min_len_r;
  logic [6:0] max_excl_r;
  logic [7:0] max_terms_r;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [7:0]    quote_r, quote_nxt;
  logic [AW-1:0] len_r, len_nxt;
  logic [7:0]    found_r, found_nxt;
  logic [7:0]    last_ch_r, last_ch_nxt;
  logic [AW-1:0] em_len_r, em_len_nxt;
  logic [7:0]    em_idx_r, em_idx_nxt;
  logic          em_eot_r, em_eot_nxt;
  logic [AW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [7:0]    pend_ch_r, pend_ch_nxt;

  logic          rd_v_r, rd_v_nxt;
  logic          rd_last_r;
  logic [7:0]    rd_idx_r;
  logic [7:0]    rd_data_r;
  logic          rd_issue;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  cte_pkg::res_t head_r, skid_r, push_data;
  logic          head_v_r, skid_v_r;
  logic          push, pop, sum_push;
  logic [1:0]    occ;
  logic          room;

  logic          accept;
  logic [7:0]    b;
  logic          can_put;
  logic          emit_ok;
  logic          split;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign b          = in_tdata;
  assign can_put    = (len_r < LEN_CAP);
  assign emit_ok    = (len_r != '0) && (CW'(len_r) >= CW'(min_len_r)) &&
                      (CW'(len_r) < CW'(max_excl_r)) && (found_r < max_terms_r);
  assign split      = (mode_r == cte_pkg::MODE_WORD) && (len_r != '0) &&
                      (cte_pkg::is_lower(last_ch_r) || cte_pkg::is_digit(last_ch_r));

  assign pop  = head_v_r && out_tready;
  assign occ  = 2'({1'b0, head_v_r}) + 2'({1'b0, skid_v_r}) + 2'({1'b0, rd_v_r});
  assign room = (occ < 2'd2) || ((occ == 2'd2) && pop);

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    quote_nxt   = quote_r;
    len_nxt     = len_r;
    found_nxt   = found_r;
    last_ch_nxt = last_ch_r;
    em_len_nxt  = em_len_r;
    em_idx_nxt  = em_idx_r;
    em_eot_nxt  = em_eot_r;
    rd_cnt_nxt  = rd_cnt_r;
    pend_nxt    = pend_r;
    pend_ch_nxt = pend_ch_r;
    rd_v_nxt    = 1'b0;
    rd_issue    = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = len_r;
    wr_data     = b;
    sum_push    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser) begin
            em_eot_nxt = 1'b1;
            if ((mode_r != cte_pkg::MODE_GAP) && emit_ok) begin
              em_len_nxt = len_r;
              em_idx_nxt = found_r;
              found_nxt  = found_r + 8'd1;
              rd_cnt_nxt = '0;
              state_nxt  = ST_EMIT;
            end else begin
              state_nxt = ST_SUM;
            end
          end else if ((found_r < max_terms_r) && (b != 8'd0)) begin
            em_eot_nxt = 1'b0;
            em_len_nxt = len_r;
            em_idx_nxt = found_r;
            rd_cnt_nxt = '0;
            if (mode_r == cte_pkg::MODE_QUOTE) begin
              if (b == quote_r) begin
                if (emit_ok) begin
                  found_nxt = found_r + 8'd1;
                  state_nxt = ST_EMIT;
                end
                len_nxt  = '0;
                mode_nxt = cte_pkg::MODE_GAP;
              end else if (can_put) begin
                wr_en       = 1'b1;
                len_nxt     = len_r + AW'(1);
                last_ch_nxt = b;
              end
            end else if (cte_pkg::is_quote(b)) begin
              mode_nxt  = cte_pkg::MODE_QUOTE;
              quote_nxt = b;
              len_nxt   = '0;
            end else if (cte_pkg::is_sep(b)) begin
              if ((mode_r == cte_pkg::MODE_WORD) && emit_ok) begin
                found_nxt = found_r + 8'd1;
                state_nxt = ST_EMIT;
              end
              len_nxt  = '0;
              mode_nxt = cte_pkg::MODE_GAP;
            end else if (cte_pkg::is_lower(b) || cte_pkg::is_digit(b)) begin
              if ((mode_r == cte_pkg::MODE_WORD) && can_put) begin
                wr_en       = 1'b1;
                len_nxt     = len_r + AW'(1);
                last_ch_nxt = b;
              end
            end else if (cte_pkg::is_upper(b)) begin
              last_ch_nxt = b;
              if (split && emit_ok) begin
                // buffer busy with readout; first char of new word written afterwards
                found_nxt   = found_r + 8'd1;
                state_nxt   = ST_EMIT;
                pend_nxt    = 1'b1;
                pend_ch_nxt = b;
                len_nxt     = AW'(1);
                mode_nxt    = cte_pkg::MODE_WORD;
              end else if (split || (mode_r != cte_pkg::MODE_WORD)) begin
                wr_en    = 1'b1;
                wr_addr  = '0;
                len_nxt  = AW'(1);
                mode_nxt = cte_pkg::MODE_WORD;
              end else if (can_put) begin
                wr_en   = 1'b1;
                len_nxt = len_r + AW'(1);
              end
            end
          end
        end
      end
      ST_EMIT: begin
        if (room) begin
          rd_issue   = 1'b1;
          rd_v_nxt   = 1'b1;
          rd_cnt_nxt = rd_cnt_r + AW'(1);
          if (rd_cnt_r == em_len_r - AW'(1)) begin
            if (pend_r) begin
              wr_en    = 1'b1;
              wr_addr  = '0;
              wr_data  = pend_ch_r;
              pend_nxt = 1'b0;
            end
            state_nxt = em_eot_r ? ST_SUM : ST_IDLE;
          end
        end
      end
      ST_SUM: begin
        if (!rd_v_r && room) begin
          sum_push  = 1'b1;
          mode_nxt  = cte_pkg::MODE_GAP;
          quote_nxt = 8'd0;
          len_nxt   = '0;
          found_nxt = 8'd0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_issue) begin
      rd_data_r <= mem[rd_cnt_r];
      rd_last_r <= (rd_cnt_r == em_len_r - AW'(1));
      rd_idx_r  <= em_idx_r;
    end
  end

  assign push = rd_v_r || sum_push;

  always_comb begin
    push_data = '0;
    if (rd_v_r) begin
      push_data.chr  = rd_data_r;
      push_data.idx  = rd_idx_r;
      push_data.last = rd_last_r;
    end else begin
      push_data.done  = 1'b1;
      push_data.total = found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        head_r   <= skid_r;
        skid_v_r <= push;
        skid_r   <= push_data;
      end else begin
        head_v_r <= push;
        head_r   <= push_data;
      end
    end else if (!head_v_r) begin
      head_v_r <= push;
      head_r   <= push_data;
    end else if (push) begin
      skid_v_r <= 1'b1;
      skid_r   <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r   <= cte_pkg::MIN_LEN_RST[5:0];
      max_excl_r  <= cte_pkg::MAX_EXCL_RST[6:0];
      max_terms_r <= cte_pkg::MAX_TERMS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        cte_pkg::REG_MIN_LEN:   min_len_r   <= cfg_wdata[5:0];
        cte_pkg::REG_MAX_EXCL:  max_excl_r  <= cfg_wdata[6:0];
        cte_pkg::REG_MAX_TERMS: max_terms_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= cte_pkg::MODE_GAP;
      quote_r   <= 8'd0;
      len_r     <= '0;
      found_r   <= 8'd0;
      last_ch_r <= 8'd0;
      em_eot_r  <= 1'b0;
      rd_cnt_r  <= '0;
      pend_r    <= 1'b0;
      rd_v_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      quote_r   <= quote_nxt;
      len_r     <= len_nxt;
      found_r   <= found_nxt;
      last_ch_r <= last_ch_nxt;
      em_eot_r  <= em_eot_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      pend_r    <= pend_nxt;
      rd_v_r    <= rd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    em_len_r  <= em_len_nxt;
    em_idx_r  <= em_idx_nxt;
    pend_ch_r <= pend_ch_nxt;
  end

  assign out_tvalid = head_v_r;
  assign out_tdata  = {head_r.total, head_r.idx, head_r.chr};
  assign out_tlast  = head_r.last;
  assign out_tuser  = head_r.done;

endmodule

// File: sim/tb.sv
module tb;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;
  localparam int   TERM_CAP  = 63;
  localparam int   HOLD_LONG = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] text_byte
  logic        in_tuser = 1'b0; // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [7:0] term_char, [15:8] term_index, [23:16] term_total
  logic        out_tlast;
  logic        out_tuser;       // [0] done_res
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [7:0]  cfg_wdata = '0;

  camelcase_term_extractor u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  class term_scoreboard;
    cte_pkg::res_t term_q[$];
    logic [1:0]  mode;
    logic [7:0]  qchar;
    logic [7:0]  term_chars[64];
    int unsigned len;
    logic [7:0]  found;
    logic [5:0]  min_len;
    logic [6:0]  max_excl;
    logic [7:0]  max_n;
    int          errors;
    int          chars_seen;
    int          totals_seen;

    function new();
      min_len     = cte_pkg::MIN_LEN_RST[5:0];
      max_excl    = cte_pkg::MAX_EXCL_RST[6:0];
      max_n       = cte_pkg::MAX_TERMS_RST;
      errors      = 0;
      chars_seen  = 0;
      totals_seen = 0;
      restart();
    endfunction

    function void restart();
      mode  = cte_pkg::MODE_GAP;
      qchar = '0;
      len   = 0;
      found = '0;
    endfunction

    function void set_limits(logic [5:0] lo, logic [6:0] hi, logic [7:0] n);
      min_len  = lo;
      max_excl = hi;
      max_n    = n;
    endfunction

    function int pending();
      return term_q.size();
    endfunction

    function bit up_ch(logic [7:0] c);
      return c >= 8'h41 && c <= 8'h5A;
    endfunction

    function bit low_ch(logic [7:0] c);
      return c >= 8'h61 && c <= 8'h7A;
    endfunction

    function bit dig_ch(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
    endfunction

    function bit quote_ch(logic [7:0] c);
      return c == cte_pkg::CH_BACKTICK || c == cte_pkg::CH_DQUOTE || c == cte_pkg::CH_SQUOTE;
    endfunction

    function bit gap_ch(logic [7:0] c);
      if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
        return 1'b1;
      return c >= 8'h21 && c <= 8'h7E && !up_ch(c) && !low_ch(c) && !dig_ch(c);
    endfunction

    function void store_char(logic [7:0] c);
      if (len < TERM_CAP) begin
        term_chars[len] = c;
        len++;
      end
    endfunction

    function void flush_term();
      cte_pkg::res_t r;
      if (len == 0 || len < min_len || len >= max_excl || found >= max_n)
        return;
      for (int i = 0; i < len; i++) begin
        r.chr   = term_chars[i];
        r.idx   = found;
        r.last  = (i == len - 1);
        r.done  = 1'b0;
        r.total = '0;
        term_q.push_back(r);
      end
      found++;
    endfunction

    function void note_request(logic kind, logic [7:0] b);
      cte_pkg::res_t r;
      logic [7:0] prev;
      if (kind == KIND_END) begin
        if (mode == cte_pkg::MODE_WORD || mode == cte_pkg::MODE_QUOTE)
          flush_term();
        r.chr   = '0;
        r.idx   = '0;
        r.last  = 1'b0;
        r.done  = 1'b1;
        r.total = found;
        term_q.push_back(r);
        restart();
        return;
      end
      if (found >= max_n || b == 8'h00)
        return;
      if (mode == cte_pkg::MODE_QUOTE) begin
        if (b == qchar) begin
          flush_term();
          len  = 0;
          mode = cte_pkg::MODE_GAP;
        end else begin
          store_char(b);
        end
      end else if (quote_ch(b)) begin
        mode  = cte_pkg::MODE_QUOTE;
        qchar = b;
        len   = 0;
      end else if (gap_ch(b)) begin
        if (mode == cte_pkg::MODE_WORD)
          flush_term();
        len  = 0;
        mode = cte_pkg::MODE_GAP;
      end else if (low_ch(b) || dig_ch(b)) begin
        if (mode == cte_pkg::MODE_WORD)
          store_char(b);
      end else if (up_ch(b)) begin
        // camel split looks at the last stored char
        if (mode == cte_pkg::MODE_WORD && len > 0) begin
          prev = term_chars[len - 1];
          if (low_ch(prev) || dig_ch(prev)) begin
            flush_term();
            mode = cte_pkg::MODE_GAP;
          end
        end
        if (mode != cte_pkg::MODE_WORD) begin
          len  = 0;
          mode = cte_pkg::MODE_WORD;
        end
        store_char(b);
      end
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [23:0] data, logic last, logic done);
      cte_pkg::res_t got;
      cte_pkg::res_t want;
      got.chr   = data[7:0];
      got.idx   = data[15:8];
      got.total = data[23:16];
      got.last  = last;
      got.done  = done;
      if (term_q.size() == 0) begin
        report($sformatf("unexpected result chr %h idx %0d last %b done %b total %0d",
                         got.chr, got.idx, got.last, got.done, got.total));
        return;
      end
      want = term_q.pop_front();
      if (got !== want)
        report($sformatf("chr %h/%h idx %0d/%0d last %b/%b done %b/%b total %0d/%0d",
                         got.chr, want.chr, got.idx, want.idx, got.last, want.last,
                         got.done, want.done, got.total, want.total));
      if (done)
        totals_seen++;
      else
        chars_seen++;
    endtask
  endclass

  term_scoreboard sb = new();

  int sent = 0;
  int texts = 0;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;
  bit long_hold = 1'b0;

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_req(input logic kind, input logic [7:0] b);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_request(kind, b);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_req(KIND_TEXT, s[i]);
  endtask

  task automatic send_end();
    send_req(KIND_END, 8'($urandom_range(0, 255)));
    texts++;
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 8'(8'h61 + $urandom_range(0, 25));
    if (r < 85)
      return 8'(8'h30 + $urandom_range(0, 9));
    return 8'(8'h41 + $urandom_range(0, 25));
  endfunction

  task automatic send_word(input int n);
    send_req(KIND_TEXT, 8'(8'h41 + $urandom_range(0, 25)));
    repeat (n) send_req(KIND_TEXT, word_char());
  endtask

  task automatic send_quoted(input int n);
    logic [7:0] q;
    logic [7:0] c;
    case ($urandom_range(0, 2))
      0: q = cte_pkg::CH_BACKTICK;
      1: q = cte_pkg::CH_DQUOTE;
      default: q = cte_pkg::CH_SQUOTE;
    endcase
    send_req(KIND_TEXT, q);
    repeat (n) begin
      c = 8'($urandom_range(0, 255));
      if (c == q && $urandom_range(0, 3) != 0)
        c = word_char();
      send_req(KIND_TEXT, c);
    end
    if ($urandom_range(0, 9) != 0)
      send_req(KIND_TEXT, q);
  endtask

  task automatic send_sep();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: c = 8'h20;
      1: c = 8'h09;
      2: c = 8'h0D;
      3: c = 8'h5F;
      4: c = 8'h2E;
      5: c = 8'h2C;
      6: c = 8'h2D;
      default: c = 8'(8'h21 + $urandom_range(0, 14));
    endcase
    send_req(KIND_TEXT, c);
  endtask

  // wait for every expected result, then let in-flight bytes finish
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_regs(input logic [5:0] lo, input logic [6:0] hi, input logic [7:0] n);
    cfg_we    <= 1'b1;
    cfg_addr  <= cte_pkg::REG_MIN_LEN;
    cfg_wdata <= {2'b00, lo};
    @(posedge clk);
    cfg_addr  <= cte_pkg::REG_MAX_EXCL;
    cfg_wdata <= {1'b0, hi};
    @(posedge clk);
    cfg_addr  <= cte_pkg::REG_MAX_TERMS;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limits(lo, hi, n);
  endtask

  initial begin
    int hold;
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      hold = long_hold ? HOLD_LONG : 0;
      long_hold = 1'b0;
      gap = out_quiet ? 0 : $urandom_range(0, 6);
      if (hold + gap > 0) begin
        out_tready <= 1'b0;
        repeat (hold + gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid && !long_hold);
      if (out_tvalid)
        sb.check_result(out_tdata, out_tlast, out_tuser);
    end
  end

  initial begin
    int phase;
    int target;
    int n;
    int odds;
    int r;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: quote drops word, zero in quote, camel split, underscore,
    // lowercase outside a word, ignored bytes, empty quote, flush at end
    send_text("Ab`x");
    send_req(KIND_TEXT, 8'h00);
    send_text("y`Cd9Ef_g");
    send_req(KIND_TEXT, 8'hFF);
    send_req(KIND_TEXT, 8'h7F);
    send_req(KIND_TEXT, 8'h80);
    send_req(KIND_TEXT, 8'h01);
    send_text("\t''Hi\"Zz");
    send_req(KIND_END, 8'hFF);
    texts++;

    phase = 0;
    while (sent < 470) begin
      phase++;
      settle();
      case (phase)
        1: load_regs(6'd1, 7'd64, 8'd255);
        2: load_regs(6'd63, 7'd64, 8'd255);
        3: load_regs(6'd1, 7'd2, 8'd1);
        4: load_regs(cte_pkg::MIN_LEN_RST[5:0], cte_pkg::MAX_EXCL_RST[6:0],
                     cte_pkg::MAX_TERMS_RST);
        default: load_regs(6'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 63)
                                                           : $urandom_range(1, 6)),
                           7'($urandom_range(2, 64)),
                           8'(($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 10)));
      endcase
      in_quiet  = (phase % 4 == 1);
      out_quiet = (phase % 4 == 3);
      if (phase == 1)
        long_hold = 1'b1;
      odds = (phase == 2) ? 3 : 12;
      target = sent + 50;
      while (sent < target) begin
        n = ($urandom_range(1, odds) == 1) ? $urandom_range(55, 70) : $urandom_range(0, 8);
        r = $urandom_range(0, 99);
        if (r < 45)
          send_word(n);
        else if (r < 62)
          send_quoted(n);
        else if (r < 85)
          send_sep();
        else
          send_req(KIND_TEXT, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 11) == 0)
          send_end();
      end
      // some phases leave the text open across the register change
      if ($urandom_range(0, 4) != 0)
        send_end();
    end
    send_end();
    in_tvalid <= 1'b0;

    for (int w = 0; w < 20000 && sb.pending() > 0; w++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.pending() > 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    $display("run covered %0d requests over %0d texts in %0d register phases",
             sent, texts, phase + 1);
    $display("checked %0d term characters and %0d end-of-text summaries",
             sb.chars_seen, sb.totals_seen);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
hdl/cte_pkg.sv
hdl/camelcase_term_extractor.sv
sim/tb.sv
